[rtl/core/kbd_mouse_packet_decoder_defines.svh]
// ----------------------------------------------------------------------------
// kbd_mouse_packet_decoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KBD_MOUSE_PACKET_DECODER_DEFINES_SVH
`define KBD_MOUSE_PACKET_DECODER_DEFINES_SVH

// same-cycle implication
`define KBDM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kbdm assertion failed");

// next-cycle implication
`define KBDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kbdm assertion failed");

`endif

[rtl/core/kbdm_pkg.sv]
// ----------------------------------------------------------------------------
// kbdm_pkg
// Types and constants of the keyboard/mouse packet decoder.
// ----------------------------------------------------------------------------
package kbdm_pkg;

   localparam int FIFO_DEPTH = 256;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam int XLIM_W  = 10;
   localparam int YLIM_W  = 9;
   localparam int CSR_W   = 10;
   localparam int KEYS_W  = 9;
   localparam int RSP_D_W = 40;

   localparam logic [XLIM_W-1:0] X_LIMIT_RESET = 10'd632;
   localparam logic [YLIM_W-1:0] Y_LIMIT_RESET = 9'd392;

   localparam logic [7:0] HEADER_MIN = 8'hF8;
   localparam logic [7:0] KEY_LIMIT  = 8'h80;
   localparam int         BUTTON_BIT = 1;

   localparam logic OP_RX  = 1'b0;
   localparam logic OP_POP = 1'b1;

   localparam logic CSR_X_LIMIT = 1'b0;
   localparam logic CSR_Y_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_XDELTA = 2'd2
   } phase_type;

endpackage

[rtl/core/kbdm_ram.sv]
// ----------------------------------------------------------------------------
// kbdm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kbdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/kbd_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// kbd_mouse_packet_decoder
// Keyboard-controller byte stream decoder: key FIFO and relative mouse.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: req_tuser is the opcode (0 = byte
//   from the controller in req_tdata, 1 = pop the oldest key). Every item
//   gives exactly one result on rsp_*: key, pointer position, button and
//   the number of keys still queued after that item.
//   csr_we/csr_index/csr_wdata set the clamp ceilings (0 = x, 1 = y); write
//   them only while no item is in flight.
//   The key RAM read and the read stage load at the accepting edge; the
//   output register loads from them once it is free and drives rsp_tvalid.
//   Throughput is one item per cycle unless rsp_tready stalls; the key RAM
//   takes at most one write (push) or one read (pop) per item.
//   When rsp_tready is low the read stage and the output register hold up
//   to two results; req_tready drops only once both are full.
//   Reset (synchronous) clears the pointer, button, packet phase, FIFO
//   pointers and fill count and loads the default limits. The key RAM is
//   not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
`include "kbd_mouse_packet_decoder_defines.svh"

module kbd_mouse_packet_decoder (
   input  logic                         clock,
   input  logic                         reset,
   // request: tdata = rx_byte[7:0]; tuser = opcode
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tuser,
   // response: tdata = key_code[7:0], pointer_x[17:8], pointer_y[26:18],
   //   button_down[27], keys_waiting[36:28], zero[39:37]; tuser = key_valid
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [kbdm_pkg::RSP_D_W-1:0] rsp_tdata,
   output logic                         rsp_tuser,
   // configuration
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [kbdm_pkg::CSR_W-1:0]   csr_wdata
);

   import kbdm_pkg::*;

   logic [XLIM_W-1:0] x_limit_ff;
   logic [YLIM_W-1:0] y_limit_ff;

   phase_type         phase_ff, phase_in;
   logic [7:0]        header_ff, header_in;
   logic [7:0]        held_x_ff, held_x_in;
   logic [9:0]        pos_x_ff, pos_x_in;
   logic [8:0]        pos_y_ff, pos_y_in;
   logic              button_ff, button_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  fill_count_ff, fill_count_in;

   // read stage (RAM data lines up with it)
   logic              p1_valid_ff;
   logic              p1_key_valid_ff;
   logic [9:0]        p1_pos_x_ff;
   logic [8:0]        p1_pos_y_ff;
   logic              p1_button_ff;
   logic [KEYS_W-1:0] p1_keys_ff;

   // output register
   logic              out_valid_ff;
   logic [7:0]        out_key_ff;
   logic              out_key_valid_ff;
   logic [9:0]        out_pos_x_ff;
   logic [8:0]        out_pos_y_ff;
   logic              out_button_ff;
   logic [KEYS_W-1:0] out_keys_ff;

   logic              req_accept;
   logic              is_pop;
   logic              pop_hit;
   logic              push;
   logic              out_load;
   logic [7:0]        rd_data;
   logic [11:0]       sum_x;
   logic [10:0]       sum_y;
   logic [9:0]        clamp_x;
   logic [8:0]        clamp_y;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !p1_valid_ff || out_load;
   assign req_accept = req_tvalid && req_tready;
   assign is_pop     = (req_tuser == OP_POP);
   assign pop_hit    = req_accept && is_pop && (fill_count_ff != '0);
   assign push       = req_accept && !is_pop && (phase_ff != PH_HEADER)
                       && (phase_ff != PH_XDELTA) && (req_tdata < KEY_LIMIT)
                       && (fill_count_ff < CNT_W'(FIFO_DEPTH));

   // signed delta added on a widened unsigned position; top bit flags < 0
   assign sum_x = {2'b00, pos_x_ff} + {{4{held_x_ff[7]}}, held_x_ff};
   assign sum_y = {2'b00, pos_y_ff} + {{3{req_tdata[7]}}, req_tdata};

   always_comb begin
      if (sum_x[11]) begin
         clamp_x = '0;
      end else if (sum_x[10:0] > {1'b0, x_limit_ff}) begin
         clamp_x = x_limit_ff;
      end else begin
         clamp_x = sum_x[9:0];
      end
      if (sum_y[10]) begin
         clamp_y = '0;
      end else if (sum_y[9:0] > {1'b0, y_limit_ff}) begin
         clamp_y = y_limit_ff;
      end else begin
         clamp_y = sum_y[8:0];
      end
   end

   // packet phase next state
   always_comb begin
      phase_in = phase_ff;
      if (req_accept && !is_pop) begin
         case (phase_ff)
            PH_HEADER: phase_in = PH_XDELTA;
            PH_XDELTA: phase_in = PH_IDLE;
            default: begin
               phase_in = (req_tdata >= HEADER_MIN) ? PH_HEADER : PH_IDLE;
            end
         endcase
      end
   end

   // packet datapath
   always_comb begin
      header_in = header_ff;
      held_x_in = held_x_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      button_in = button_ff;
      if (req_accept && !is_pop) begin
         case (phase_ff)
            PH_HEADER: held_x_in = req_tdata;
            PH_XDELTA: begin
               pos_x_in  = clamp_x;
               pos_y_in  = clamp_y;
               button_in = header_ff[BUTTON_BIT];
            end
            default: begin
               if (req_tdata >= HEADER_MIN) begin
                  header_in = req_tdata;
               end
            end
         endcase
      end
   end

   // FIFO bookkeeping
   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_count_in = fill_count_ff;
      if (pop_hit) begin
         rd_ptr_in     = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         fill_count_in = fill_count_ff - 1'b1;
      end else if (push) begin
         wr_ptr_in     = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         fill_count_in = fill_count_ff + 1'b1;
      end
   end

   // a pop never targets the entry written in the same cycle: fill_count > 0
   kbdm_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata),
      .rd_en   (pop_hit),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_LIMIT: x_limit_ff <= csr_wdata[XLIM_W-1:0];
            CSR_Y_LIMIT: y_limit_ff <= csr_wdata[YLIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         header_ff     <= '0;
         held_x_ff     <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         button_ff     <= 1'b0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         fill_count_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         header_ff     <= header_in;
         held_x_ff     <= held_x_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         button_ff     <= button_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         fill_count_ff <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            p1_valid_ff <= 1'b1;
         end else if (out_load) begin
            p1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= p1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_key_valid_ff <= pop_hit;
         p1_pos_x_ff     <= pos_x_in;
         p1_pos_y_ff     <= pos_y_in;
         p1_button_ff    <= button_in;
         p1_keys_ff      <= KEYS_W'(fill_count_in);
      end
      if (out_load && p1_valid_ff) begin
         out_key_ff       <= p1_key_valid_ff ? rd_data : 8'h00;
         out_key_valid_ff <= p1_key_valid_ff;
         out_pos_x_ff     <= p1_pos_x_ff;
         out_pos_y_ff     <= p1_pos_y_ff;
         out_button_ff    <= p1_button_ff;
         out_keys_ff      <= p1_keys_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_key_valid_ff;
   assign rsp_tdata  = {3'b000, out_keys_ff, out_button_ff, out_pos_y_ff,
                        out_pos_x_ff, out_key_ff};

   `KBDM_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_count_ff <= CNT_W'(FIFO_DEPTH))
   `KBDM_ASSERT_NEXT(a_pop_stage, clock, reset, pop_hit, p1_valid_ff && p1_key_valid_ff)
   `KBDM_ASSERT_NEXT(a_pop_count, clock, reset, pop_hit, fill_count_ff == $past(fill_count_ff) - 1'b1)

endmodule

[bench/tb_kbd_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// tb_kbd_mouse_packet_decoder
// Self-checking bench for the keyboard/mouse packet decoder. Drives a
// directed run and then random controller byte streams (keys, mouse packets,
// broken packets, noise, pops) through the request stream while both sides
// idle at random. A scoreboard predicts every response from its own model
// of the key FIFO, packet state and clamped pointer and compares each field.
// ----------------------------------------------------------------------------
module tb_kbd_mouse_packet_decoder;

   import kbdm_pkg::*;

   localparam int HOLD_CYCLES = 80;

   typedef struct {
      logic [7:0]        key_code;
      logic              key_valid;
      logic [XLIM_W-1:0] pointer_x;
      logic [YLIM_W-1:0] pointer_y;
      logic              button_down;
      logic [KEYS_W-1:0] keys_waiting;
      logic [2:0]        pad;
   } decoder_result_type;

   class decoder_scoreboard;
      logic [XLIM_W-1:0]  x_limit;
      logic [YLIM_W-1:0]  y_limit;
      phase_type          phase;
      logic [7:0]         header;
      logic [7:0]         x_delta;
      logic [XLIM_W-1:0]  pos_x;
      logic [YLIM_W-1:0]  pos_y;
      logic               button;
      logic [7:0]         key_queue[$];
      decoder_result_type pending_results[$];
      int                 errors;

      function new();
         x_limit = X_LIMIT_RESET;
         y_limit = Y_LIMIT_RESET;
         phase   = PH_IDLE;
         header  = '0;
         x_delta = '0;
         pos_x   = '0;
         pos_y   = '0;
         button  = 1'b0;
         errors  = 0;
      endfunction

      function void write_limit(logic idx, logic [CSR_W-1:0] value);
         if (idx == CSR_X_LIMIT) x_limit = value[XLIM_W-1:0];
         else                    y_limit = value[YLIM_W-1:0];
      endfunction

      function int clamped_move(int pos, logic [7:0] delta, int limit);
         int sum;
         sum = pos + int'($signed(delta));
         if (sum < 0) return 0;
         if (sum > limit) return limit;
         return sum;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_item(logic op, logic [7:0] data);
         decoder_result_type r;
         r.key_code  = '0;
         r.key_valid = 1'b0;
         if (op == OP_POP) begin
            if (key_queue.size() > 0) begin
               r.key_code  = key_queue.pop_front();
               r.key_valid = 1'b1;
            end
         end else begin
            case (phase)
               PH_HEADER: begin
                  x_delta = data;
                  phase   = PH_XDELTA;
               end
               PH_XDELTA: begin
                  pos_x  = XLIM_W'(clamped_move(int'(pos_x), x_delta, int'(x_limit)));
                  pos_y  = YLIM_W'(clamped_move(int'(pos_y), data, int'(y_limit)));
                  button = header[BUTTON_BIT];
                  phase  = PH_IDLE;
               end
               default: begin
                  phase = PH_IDLE;
                  if (data < KEY_LIMIT) begin
                     // full FIFO drops the key
                     if (key_queue.size() < FIFO_DEPTH) key_queue.push_back(data);
                  end else if (data >= HEADER_MIN) begin
                     header = data;
                     phase  = PH_HEADER;
                  end
               end
            endcase
         end
         r.pointer_x    = pos_x;
         r.pointer_y    = pos_y;
         r.button_down  = button;
         r.keys_waiting = KEYS_W'(key_queue.size());
         r.pad          = '0;
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            errors++;
         end
      endfunction

      function void check_result(decoder_result_type got);
         decoder_result_type want;
         if (pending_results.size() == 0) begin
            $display({"%0t: unexpected result: expected none, ",
                      "actual key=%0h valid=%0b x=%0d y=%0d"},
                     $time, got.key_code, got.key_valid, got.pointer_x, got.pointer_y);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("key_code", int'(want.key_code), int'(got.key_code));
         compare_field("key_valid", int'(want.key_valid), int'(got.key_valid));
         compare_field("pointer_x", int'(want.pointer_x), int'(got.pointer_x));
         compare_field("pointer_y", int'(want.pointer_y), int'(got.pointer_y));
         compare_field("button_down", int'(want.button_down), int'(got.button_down));
         compare_field("keys_waiting", int'(want.keys_waiting), int'(got.keys_waiting));
         compare_field("tdata padding", int'(want.pad), int'(got.pad));
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;
   logic               req_tuser  = OP_RX;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_D_W-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               csr_we     = 1'b0;
   logic               csr_index  = CSR_X_LIMIT;
   logic [CSR_W-1:0]   csr_wdata  = '0;

   decoder_scoreboard sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;

   kbd_mouse_packet_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // input monitor: every accepted item gets its prediction
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_item(req_tuser, req_tdata);
   end

   // response side: check accepted results, stall at random or on a hold request
   initial begin
      decoder_result_type seen;
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            seen.key_code     = rsp_tdata[7:0];
            seen.key_valid    = rsp_tuser;
            seen.pointer_x    = rsp_tdata[17:8];
            seen.pointer_y    = rsp_tdata[26:18];
            seen.button_down  = rsp_tdata[27];
            seen.keys_waiting = rsp_tdata[36:28];
            seen.pad          = rsp_tdata[39:37];
            sb.check_result(seen);
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input logic op, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                              input logic [7:0] dy);
      send_item(OP_RX, hdr);
      send_item(OP_RX, dx);
      send_item(OP_RX, dy);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limits(input logic [CSR_W-1:0] x_value, input logic [CSR_W-1:0] y_value);
      csr_we    <= 1'b1;
      csr_index <= CSR_X_LIMIT;
      csr_wdata <= x_value;
      @(posedge clock);
      csr_index <= CSR_Y_LIMIT;
      csr_wdata <= y_value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_limit(CSR_X_LIMIT, x_value);
      sb.write_limit(CSR_Y_LIMIT, y_value);
      @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // random byte streams, mostly well-formed; noise bytes do not count
   task automatic run_mix(input int n);
      int count;
      int pick;
      count = 0;
      while (count < n) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_packet(8'($urandom_range(255, HEADER_MIN)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
            count += 3;
         end else if (pick < 65) begin
            send_item(OP_RX, 8'($urandom_range(KEY_LIMIT - 1)));
            count++;
         end else if (pick < 85) begin
            send_item(OP_POP, 8'($urandom_range(255)));
            count++;
         end else if (pick < 90) begin
            send_item(OP_RX, 8'($urandom_range(HEADER_MIN - 1, KEY_LIMIT)));
         end else begin
            // broken packet: pops inside it, or left short for the next byte
            send_item(OP_RX, 8'($urandom_range(255, HEADER_MIN)));
            if ($urandom_range(1)) send_item(OP_POP, 8'($urandom_range(255)));
            send_item(OP_RX, 8'($urandom_range(255)));
            count += 2;
         end
      end
   endtask

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, default limits
      set_idling(0, 0);
      send_item(OP_POP, 8'hFF);                 // pop on empty FIFO
      send_item(OP_RX, 8'h00);
      send_item(OP_RX, 8'h7F);
      send_item(OP_RX, 8'h80);                  // ignored while idle
      send_item(OP_RX, 8'hF7);                  // ignored while idle
      send_item(OP_POP, 8'h00);
      send_item(OP_POP, 8'hAA);
      send_item(OP_POP, 8'h55);                 // empty again
      send_packet(8'hF8, 8'h7F, 8'h7F);         // largest positive move
      send_packet(8'hFA, 8'h80, 8'h80);         // clamp at zero, button down
      send_packet(8'hFF, 8'h10, 8'h05);         // key-range bytes are deltas
      send_item(OP_RX, 8'hF8);
      send_item(OP_POP, 8'h00);                 // pop inside a packet
      send_packet(8'h01, 8'h01, 8'hFC);         // finishes packet, starts another
      send_item(OP_RX, 8'hF9);                  // header byte taken as delta
      send_item(OP_RX, 8'h00);
      wait_idle();

      run_mix(220);
      wait_idle();

      set_limits(10'd1023, 10'd511);
      set_idling(71, 0);
      repeat (10) send_packet(8'hF8, 8'h7F, 8'h7F);  // drive to the ceilings
      run_mix(190);
      wait_idle();

      // lowered limits: position stays high until the next packet
      set_limits(10'd5, 10'h203);
      set_idling(0, 71);
      send_item(OP_POP, 8'h00);
      send_item(OP_RX, 8'h22);
      run_mix(200);
      wait_idle();

      set_limits(10'd0, 10'd0);
      set_idling(8, 8);
      run_mix(200);
      wait_idle();

      // fill the FIFO past its depth, with the response side held off at first
      set_limits(CSR_W'($urandom_range(1023)), CSR_W'($urandom_range(1023)));
      set_idling(0, 0);
      hold_requests++;
      repeat (FIFO_DEPTH + 14) send_item(OP_RX, 8'($urandom_range(KEY_LIMIT - 1)));
      set_idling(0, 71);
      repeat (FIFO_DEPTH + 24) send_item(OP_POP, 8'($urandom_range(255)));
      wait_idle();

      set_limits(CSR_W'($urandom_range(1023)), CSR_W'($urandom_range(1023)));
      set_idling(71, 71);
      run_mix(150);
      wait_idle();

      set_limits(CSR_W'($urandom_range(1023)), CSR_W'($urandom_range(1023)));
      set_idling(30, 30);
      run_mix(200);
      wait_idle();

      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/kbdm_pkg.sv
rtl/core/kbdm_ram.sv
rtl/core/kbd_mouse_packet_decoder.sv
bench/tb_kbd_mouse_packet_decoder.sv
